>>> hw/rtl/gspe_pkg.sv
package gspe_pkg;

    localparam int unsigned NUM_BYTES      = 9;
    localparam int unsigned BYTE_IDX_W     = 4;
    localparam int unsigned BIT_IDX_W      = 3;
    localparam int unsigned TICK_W         = 16;
    localparam logic [TICK_W-1:0] HALF_BIT_RESET = 16'd16;

    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_IDLE  = 8'h00;

    localparam logic [BYTE_IDX_W-1:0] IDX_START = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] IDX_POLL  = 4'd1;

    // Command byte sent in each slot of the frame.
    function automatic logic [7:0] command_byte(input logic [BYTE_IDX_W-1:0] idx);
        logic [7:0] b;
        b = CMD_IDLE;
        if (idx == IDX_START) begin
            b = CMD_START;
        end else if (idx == IDX_POLL) begin
            b = CMD_POLL;
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/gspe_in_if.sv
interface gspe_in_if;
    logic valid;
    logic ready;
    logic start_scan;
    logic din_level;

    modport source (output valid, output start_scan, output din_level, input ready);
    modport sink   (input valid, input start_scan, input din_level, output ready);
endinterface

>>> hw/rtl/gspe_out_if.sv
interface gspe_out_if;
    logic       valid;
    logic       ready;
    logic       select_n;
    logic       clock_level;
    logic       command_level;
    logic       scan_done;
    logic [7:0] mode_id;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;

    modport source (
        output valid, output select_n, output clock_level, output command_level,
        output scan_done, output mode_id, output buttons_low, output buttons_high,
        output right_stick_x, output right_stick_y, output left_stick_x,
        output left_stick_y, input ready
    );
    modport sink (
        input valid, input select_n, input clock_level, input command_level,
        input scan_done, input mode_id, input buttons_low, input buttons_high,
        input right_stick_x, input right_stick_y, input left_stick_x,
        input left_stick_y, output ready
    );
endinterface

>>> hw/rtl/gamepad_serial_poll_engine_core.sv
// Gamepad poll master. Every input item is one timebase tick carrying the
// sampled data-in pin and a start request; every item yields exactly one
// result item with the pin levels after that tick and the last latched pad
// fields. An accepted start opens a frame of 9 bytes sent LSB first
// (0x01, 0x42, then seven 0x00): each bit is a clock-low half period with
// command driven, then a clock-high half period with data-in sampled on its
// first tick; a gap half period with command high follows each byte. On the
// frame's end tick select rises, scan_done pulses and mode, inverted buttons
// and the four stick bytes update. Starts are ignored while busy (including
// the end tick). The half period length in ticks is i_cfg_wdata, written
// with i_cfg_we; 0 acts as 1 and a write takes effect at once. Throughput is
// one item per clock while the skid register is empty: the tick state update
// is a single pass of logic into the state registers, and a two-entry output
// buffer (result register plus skid register) lets a tick be accepted while a
// result waits to be taken; ready drops while the skid register is full.
module gamepad_serial_poll_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gspe_pkg::TICK_W-1:0]  i_cfg_wdata,
    gspe_in_if.sink                      i_in,
    gspe_out_if.source                   o_out
);
    import gspe_pkg::*;

    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    typedef struct packed {
        logic       select_n;
        logic       clock_level;
        logic       command_level;
        logic       scan_done;
        logic [7:0] mode_id;
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] right_stick_x;
        logic [7:0] right_stick_y;
        logic [7:0] left_stick_x;
        logic [7:0] left_stick_y;
    } t_result;

    // config
    logic [TICK_W-1:0] r_half_ticks;

    // frame state
    logic                  r_busy, n_busy;
    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_rx [NUM_BYTES];
    logic                  rx_we;
    logic                  end_tick;
    logic [7:0]            r_mode, n_mode;
    logic [7:0]            r_btn_lo, n_btn_lo;
    logic [7:0]            r_btn_hi, n_btn_hi;
    logic [7:0]            r_rsx, n_rsx;
    logic [7:0]            r_rsy, n_rsy;
    logic [7:0]            r_lsx, n_lsx;
    logic [7:0]            r_lsy, n_lsy;

    // output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result res;

    logic              in_fire, out_fire;
    logic [TICK_W-1:0] half;
    logic [TICK_W:0]   tick_inc;
    logic              period_end;
    logic [7:0]        cmd_byte;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    assign half       = (r_half_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : r_half_ticks;
    assign tick_inc   = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};
    assign period_end = !(tick_inc < {1'b0, half});

    // Next tick state
    always_comb begin
        n_busy     = r_busy;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_shift    = r_shift;
        rx_we      = 1'b0;
        n_mode     = r_mode;
        n_btn_lo   = r_btn_lo;
        n_btn_hi   = r_btn_hi;
        n_rsx      = r_rsx;
        n_rsy      = r_rsy;
        n_lsx      = r_lsx;
        n_lsy      = r_lsy;
        end_tick   = 1'b0;

        if (!r_busy) begin
            if (i_in.start_scan) begin
                n_busy     = 1'b1;
                n_byte_idx = '0;
                n_bit_idx  = '0;
                n_phase    = PH_LOW;
                n_tick     = '0;
                n_shift    = '0;
            end
        end else if (!period_end) begin
            n_tick = tick_inc[TICK_W-1:0];
        end else begin
            n_tick = '0;
            unique case (r_phase)
                PH_LOW: begin
                    n_phase            = PH_HIGH;
                    n_shift[r_bit_idx] = i_in.din_level;
                end
                PH_HIGH: begin
                    if (r_bit_idx != '1) begin
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_phase   = PH_LOW;
                    end else begin
                        rx_we     = (r_byte_idx < BYTE_IDX_W'(NUM_BYTES));
                        n_bit_idx = '0;
                        n_phase   = PH_GAP;
                    end
                end
                default: begin
                    // gap: next byte, or close the frame
                    if (r_byte_idx < BYTE_IDX_W'(NUM_BYTES - 1)) begin
                        n_byte_idx = r_byte_idx + 1'b1;
                        n_phase    = PH_LOW;
                        n_shift    = '0;
                    end else begin
                        n_busy     = 1'b0;
                        n_byte_idx = '0;
                        n_bit_idx  = '0;
                        n_phase    = PH_LOW;
                        n_mode     = r_rx[1];
                        n_btn_lo   = ~r_rx[3];
                        n_btn_hi   = ~r_rx[4];
                        n_rsx      = r_rx[5];
                        n_rsy      = r_rx[6];
                        n_lsx      = r_rx[7];
                        n_lsy      = r_rx[8];
                        end_tick   = 1'b1;
                    end
                end
            endcase
        end
    end

    // Pin levels after this tick
    assign cmd_byte = command_byte(n_byte_idx);

    always_comb begin
        res.select_n      = !n_busy;
        res.clock_level   = !(n_busy && (n_phase == PH_LOW));
        res.command_level = (n_busy && (n_phase == PH_LOW)) ? cmd_byte[n_bit_idx] : 1'b1;
        res.scan_done     = end_tick;
        res.mode_id       = n_mode;
        res.buttons_low   = n_btn_lo;
        res.buttons_high  = n_btn_hi;
        res.right_stick_x = n_rsx;
        res.right_stick_y = n_rsy;
        res.left_stick_x  = n_lsx;
        res.left_stick_y  = n_lsy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_ticks <= HALF_BIT_RESET;
        end else if (i_cfg_we) begin
            r_half_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_byte_idx <= '0;
            r_bit_idx  <= '0;
            r_phase    <= PH_LOW;
            r_tick     <= '0;
            r_shift    <= '0;
            r_mode     <= '0;
            r_btn_lo   <= '0;
            r_btn_hi   <= '0;
            r_rsx      <= '0;
            r_rsy      <= '0;
            r_lsx      <= '0;
            r_lsy      <= '0;
            for (int i = 0; i < NUM_BYTES; i++) begin
                r_rx[i] <= '0;
            end
        end else if (in_fire) begin
            r_busy     <= n_busy;
            r_byte_idx <= n_byte_idx;
            r_bit_idx  <= n_bit_idx;
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_shift    <= n_shift;
            r_mode     <= n_mode;
            r_btn_lo   <= n_btn_lo;
            r_btn_hi   <= n_btn_hi;
            r_rsx      <= n_rsx;
            r_rsy      <= n_rsy;
            r_lsx      <= n_lsx;
            r_lsy      <= n_lsy;
            if (rx_we) begin
                r_rx[r_byte_idx] <= r_shift;
            end
        end
    end

    // Result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_fire && (out_fire || !r_out_valid)) begin
            r_out <= res;
        end
        if (in_fire && r_out_valid && !out_fire) begin
            r_skid <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.select_n      = r_out.select_n;
    assign o_out.clock_level   = r_out.clock_level;
    assign o_out.command_level = r_out.command_level;
    assign o_out.scan_done     = r_out.scan_done;
    assign o_out.mode_id       = r_out.mode_id;
    assign o_out.buttons_low   = r_out.buttons_low;
    assign o_out.buttons_high  = r_out.buttons_high;
    assign o_out.right_stick_x = r_out.right_stick_x;
    assign o_out.right_stick_y = r_out.right_stick_y;
    assign o_out.left_stick_x  = r_out.left_stick_x;
    assign o_out.left_stick_y  = r_out.left_stick_y;

endmodule
